### rtl/cmlc_pkg.sv
// shared types, constants and table functions of the multi-curve log-odds coupling block
// no dependencies
package cmlc_pkg;

    localparam int LANES        = 4;
    localparam int MAX_CURVES   = 4;
    localparam int EXP_BITS_DEF = 10;
    localparam int INT_STEPS    = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int E_W    = 17;
    localparam int INT_W  = 33;
    localparam int S_W    = 19;
    localparam int N_W    = 34;
    localparam int Q_BITS = 17;
    localparam int W_W    = 17;
    localparam int DIFF_W = 33;
    localparam int T_W    = 17;
    localparam int LANE_STG = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_COUNT  = 3'd1,
        CFG_INSIDE = 3'd2,
        CFG_FLOOR  = 3'd3,
        CFG_ICOEF  = 3'd4,
        CFG_KCOEF  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] prev_0;
        logic signed [15:0] prev_1;
        logic signed [15:0] prev_2;
        logic signed [15:0] prev_3;
        logic signed [15:0] curr_0;
        logic signed [15:0] curr_1;
        logic signed [15:0] curr_2;
        logic signed [15:0] curr_3;
        logic signed [15:0] lik_0;
        logic signed [15:0] lik_1;
        logic signed [15:0] lik_2;
        logic signed [15:0] lik_3;
    } t_in;

    typedef struct packed {
        logic signed [15:0] next_0;
        logic signed [15:0] next_1;
        logic signed [15:0] next_2;
        logic signed [15:0] next_3;
        logic signed [15:0] term_0;
        logic signed [15:0] term_1;
        logic signed [15:0] term_2;
        logic signed [15:0] term_3;
    } t_out;

    typedef struct packed {
        logic [LANES-1:0][15:0]       p;
        logic [LANES-1:0][15:0]       cur;
        logic [LANES-1:0][DIFF_W-1:0] diff;
    } t_side;

    // e^-x in q32 for x in q0.32, 25-term series
    function automatic logic [63:0] exp_series(input logic [63:0] x);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = 64'd1 << 32;
        sum  = signed'(term);
        for (int n = 1; n <= 24; n++) begin
            term = ((term * x) >> 32) / 64'(n);
            if ((n % 2) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        return unsigned'(sum);
    endfunction

    function automatic logic [INT_W-1:0] int_val(input int k);
        logic [63:0] h;
        logic [63:0] e1;
        logic [63:0] v;
        h  = exp_series(64'd1 << 31);
        e1 = (h * h + (64'd1 << 31)) >> 32;
        v  = 64'd1 << 32;
        for (int j = 1; j <= k; j++) begin
            v = (v * e1 + (64'd1 << 31)) >> 32;
        end
        return INT_W'(v);
    endfunction

    function automatic logic [E_W-1:0] frac_val(input int k, input int bits);
        logic [63:0] s;
        s = exp_series(64'(k) << (32 - bits));
        return E_W'((s + 64'h8000) >> 16);
    endfunction

    // round half away from zero
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int sh);
        logic signed [63:0] half;
        half = 64'sd1 <<< (sh - 1);
        return (v + half - ((v < 0) ? 64'sd1 : 64'sd0)) >>> sh;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage

### rtl/multi_curve_logodds_coupling.sv
// one item per cycle sustained while no stall holds the pipeline
// stages: capture, difference and max, two for the exp table, normaliser sum,
// 17 divider stages (one quotient bit each), weights, four lane stages
// a stall holds only as many stages as are full; bubbles are filled
// synchronous active-low reset clears valid bits and sets configuration registers to defaults
// depends on cmlc_pkg, cmlc_exp, cmlc_div, cmlc_lane
module multi_curve_logodds_coupling import cmlc_pkg::*; #(
    parameter int EXP_TABLE_BITS = EXP_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ST_EXP  = 2;
    localparam int ST_SUM  = 4;
    localparam int ST_DIV  = 5;
    localparam int ST_WGT  = ST_DIV + Q_BITS;
    localparam int ST_LANE = ST_WGT + 1;
    localparam int NSTG    = ST_LANE + LANE_STG;

    logic               r_mode;
    logic [2:0]         r_count;
    logic signed [15:0] r_inside;
    logic [15:0]        r_floor;
    logic [63:0]        r_icoef;
    logic [63:0]        r_kcoef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_count  <= 3'd1;
            r_inside <= -16'sd256;
            r_floor  <= '0;
            r_icoef  <= '0;
            r_kcoef  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_COUNT:  r_count  <= i_cfg_data[2:0];
                CFG_INSIDE: r_inside <= signed'(i_cfg_data[15:0]);
                CFG_FLOOR:  r_floor  <= i_cfg_data[15:0];
                CFG_ICOEF:  r_icoef  <= i_cfg_data;
                CFG_KCOEF:  r_kcoef  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [2:0]       cnt;
    logic [LANES-1:0] active;

    always_comb begin
        if (r_count == 3'd0) begin
            cnt = 3'd1;
        end else if (r_count > 3'(MAX_CURVES)) begin
            cnt = 3'(MAX_CURVES);
        end else begin
            cnt = r_count;
        end
        for (int i = 0; i < LANES; i++) begin
            active[i] = 3'(i) < cnt;
        end
    end

    // pipeline control
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] n_v;
    logic [NSTG-1:0] en;

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            en[k] = !i_stall || (|((~r_v) >> k));
        end
        n_v = {r_v[NSTG-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NSTG-1];

    // stage 0: capture
    t_in r_in;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_in <= i_data;
        end
    end

    logic signed [15:0] in_p [LANES];
    logic signed [15:0] in_c [LANES];
    logic signed [15:0] in_l [LANES];

    assign in_p[0] = r_in.prev_0;
    assign in_p[1] = r_in.prev_1;
    assign in_p[2] = r_in.prev_2;
    assign in_p[3] = r_in.prev_3;
    assign in_c[0] = r_in.curr_0;
    assign in_c[1] = r_in.curr_1;
    assign in_c[2] = r_in.curr_2;
    assign in_c[3] = r_in.curr_3;
    assign in_l[0] = r_in.lik_0;
    assign in_l[1] = r_in.lik_1;
    assign in_l[2] = r_in.lik_2;
    assign in_l[3] = r_in.lik_3;

    // stage 1: likelihood difference and scaling maximum
    t_side           r_sd [1:ST_WGT];
    t_side           n_sd;
    logic [T_W-1:0]  r_m;
    logic [T_W-1:0]  n_m;

    always_comb begin
        logic signed [31:0] il;
        logic signed [T_W-1:0] negp;
        n_m = '0;
        for (int i = 0; i < LANES; i++) begin
            il           = r_inside * in_l[i];
            n_sd.p[i]    = unsigned'(in_p[i]);
            n_sd.cur[i]  = unsigned'(in_c[i]);
            n_sd.diff[i] = unsigned'((DIFF_W'(in_p[i]) <<< 8) - DIFF_W'(il));
            negp         = -T_W'(in_p[i]);
            if (active[i] && !negp[T_W-1] && (unsigned'(negp) > n_m)) begin
                n_m = unsigned'(negp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_sd[1] <= n_sd;
            r_m     <= n_m;
        end
        for (int k = 2; k <= ST_WGT; k++) begin
            if (en[k]) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // stages 2 and 3: exponentials
    logic [E_W-1:0] e_one;
    logic [E_W-1:0] e_l [LANES];

    cmlc_exp #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_exp_one (
        .i_clk (i_clk),
        .i_en  (en[ST_EXP +: 2]),
        .i_t   (r_m),
        .o_e   (e_one)
    );

    for (genvar i = 0; i < LANES; i++) begin : g_exp
        logic [T_W:0] tsum;
        assign tsum = (T_W+1)'(r_m) + (T_W+1)'(signed'(r_sd[1].p[i]));
        cmlc_exp #(
            .EXP_TABLE_BITS (EXP_TABLE_BITS)
        ) u_exp (
            .i_clk (i_clk),
            .i_en  (en[ST_EXP +: 2]),
            .i_t   (tsum[T_W-1:0]),
            .o_e   (e_l[i])
        );
    end

    // stage 4: normaliser and dividends
    logic [S_W-1:0] r_s;
    logic [N_W-1:0] r_num [LANES];
    logic [S_W-1:0] n_s;
    logic [N_W-1:0] n_num [LANES];

    always_comb begin
        n_s = S_W'(e_one);
        for (int i = 0; i < LANES; i++) begin
            if (active[i]) begin
                n_s = n_s + S_W'(e_l[i]);
            end
        end
        for (int i = 0; i < LANES; i++) begin
            n_num[i] = N_W'(n_s >> 1);
            if (active[i]) begin
                n_num[i] = n_num[i] + (N_W'(e_l[i]) << 16);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_SUM]) begin
            r_s   <= n_s;
            r_num <= n_num;
        end
    end

    // stages 5 to 21: probabilities
    logic [Q_BITS-1:0] q [LANES];

    for (genvar i = 0; i < LANES; i++) begin : g_div
        cmlc_div u_div (
            .i_clk (i_clk),
            .i_en  (en[ST_DIV +: Q_BITS]),
            .i_num (r_num[i]),
            .i_den (r_s),
            .o_q   (q[i])
        );
    end

    // stage 22: weights and coupling masks
    logic [LANES-1:0][W_W-1:0] r_w  [LANES];
    logic [LANES-1:0]          r_cm [LANES];
    logic [LANES-1:0][W_W-1:0] n_w  [LANES];
    logic [LANES-1:0]          n_cm [LANES];

    always_comb begin
        logic [33:0]    pw;
        logic [W_W-1:0] sw;
        for (int i = 0; i < LANES; i++) begin
            for (int j = 0; j < LANES; j++) begin
                if (i == j) begin
                    pw = 34'(q[i]) * 34'(17'h10000 - q[i]) + 34'h8000;
                    sw = W_W'(pw >> 16);
                    n_w[i][j] = (sw < {1'b0, r_floor}) ? {1'b0, r_floor} : sw;
                    n_cm[i][j] = 1'b0;
                end else begin
                    pw = 34'(q[i]) * 34'(q[j]) + 34'h8000;
                    n_w[i][j] = W_W'(pw >> 16);
                    n_cm[i][j] = active[j] && (q[i] != '0) && (q[j] != '0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_WGT]) begin
            r_w  <= n_w;
            r_cm <= n_cm;
        end
    end

    // stages 23 to 26: lane updates
    logic signed [15:0] nx [LANES];
    logic signed [15:0] tm [LANES];

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        cmlc_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (en[ST_LANE +: LANE_STG]),
            .i_mode     (r_mode),
            .i_active   (active[i]),
            .i_ci       (signed'(r_icoef[16*i +: 16])),
            .i_ki       (signed'(r_kcoef[16*i +: 16])),
            .i_w        (r_w[i]),
            .i_wself    (r_w[i][i]),
            .i_cmask    (r_cm[i]),
            .i_p        (r_sd[ST_WGT].p),
            .i_diff     (r_sd[ST_WGT].diff),
            .i_p_own    (signed'(r_sd[ST_WGT].p[i])),
            .i_diff_own (signed'(r_sd[ST_WGT].diff[i])),
            .i_cur      (signed'(r_sd[ST_WGT].cur[i])),
            .o_next     (nx[i]),
            .o_term     (tm[i])
        );
    end

    assign o_data.next_0 = nx[0];
    assign o_data.next_1 = nx[1];
    assign o_data.next_2 = nx[2];
    assign o_data.next_3 = nx[3];
    assign o_data.term_0 = tm[0];
    assign o_data.term_1 = tm[1];
    assign o_data.term_2 = tm[2];
    assign o_data.term_3 = tm[3];

endmodule

### rtl/cmlc_exp.sv
// two-stage e^-t unit: table lookup, then product of integer and fraction parts
// depends on cmlc_pkg
module cmlc_exp import cmlc_pkg::*; #(
    parameter int EXP_TABLE_BITS = EXP_BITS_DEF
) (
    input  logic           i_clk,
    input  logic [1:0]     i_en,
    input  logic [T_W-1:0] i_t,
    output logic [E_W-1:0] o_e
);

    localparam int FR_N = 1 << EXP_TABLE_BITS;

    logic [E_W-1:0]   frac_rom [FR_N];
    logic [INT_W-1:0] int_rom  [INT_STEPS];

    for (genvar k = 0; k < FR_N; k++) begin : g_frac
        localparam logic [E_W-1:0] FV = frac_val(k, EXP_TABLE_BITS);
        assign frac_rom[k] = FV;
    end

    for (genvar k = 0; k < INT_STEPS; k++) begin : g_int
        localparam logic [INT_W-1:0] IV = int_val(k);
        assign int_rom[k] = IV;
    end

    logic [EXP_TABLE_BITS-1:0] idx;
    logic                      big;
    logic [INT_W-1:0]          r_int;
    logic [E_W-1:0]            r_frac;
    logic                      r_zero;
    logic [INT_W+E_W:0]        prod;
    logic [E_W-1:0]            r_e;

    assign idx = EXP_TABLE_BITS'((32'(i_t[7:0]) << EXP_TABLE_BITS) >> 8);
    assign big = |i_t[T_W-1:12];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_int  <= int_rom[i_t[11:8]];
            r_frac <= frac_rom[idx];
            r_zero <= big;
        end
    end

    assign prod = (INT_W+E_W+1)'(r_int) * (INT_W+E_W+1)'(r_frac)
                + ((INT_W+E_W+1)'(1) << 31);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_e <= r_zero ? '0 : E_W'(prod >> 32);
        end
    end

    assign o_e = r_e;

endmodule

### rtl/cmlc_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on cmlc_pkg
module cmlc_div import cmlc_pkg::*; (
    input  logic              i_clk,
    input  logic [Q_BITS-1:0] i_en,
    input  logic [N_W-1:0]    i_num,
    input  logic [S_W-1:0]    i_den,
    output logic [Q_BITS-1:0] o_q
);

    logic [S_W-1:0]    r_rem [Q_BITS];
    logic [Q_BITS-1:0] r_low [Q_BITS];
    logic [Q_BITS-1:0] r_quo [Q_BITS];
    logic [S_W-1:0]    r_den [Q_BITS];

    logic [S_W-1:0]    n_rem [Q_BITS];
    logic [Q_BITS-1:0] n_low [Q_BITS];
    logic [Q_BITS-1:0] n_quo [Q_BITS];
    logic [S_W-1:0]    n_den [Q_BITS];

    always_comb begin
        logic [S_W-1:0]    sr;
        logic [Q_BITS-1:0] sl;
        logic [Q_BITS-1:0] sq;
        logic [S_W-1:0]    sd;
        logic [S_W:0]      trial;
        logic              ge;
        for (int k = 0; k < Q_BITS; k++) begin
            if (k == 0) begin
                sr = S_W'(i_num[N_W-1:Q_BITS]);
                sl = i_num[Q_BITS-1:0];
                sq = '0;
                sd = i_den;
            end else begin
                sr = r_rem[k-1];
                sl = r_low[k-1];
                sq = r_quo[k-1];
                sd = r_den[k-1];
            end
            trial    = {sr, sl[Q_BITS-1]};
            ge       = trial >= {1'b0, sd};
            n_rem[k] = ge ? S_W'(trial - {1'b0, sd}) : S_W'(trial);
            n_low[k] = sl << 1;
            n_quo[k] = {sq[Q_BITS-2:0], ge};
            n_den[k] = sd;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_BITS; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_q = r_quo[Q_BITS-1];

endmodule

### rtl/cmlc_lane.sv
// per-curve update: weighted products, accumulation, rounding and saturation
// depends on cmlc_pkg
module cmlc_lane import cmlc_pkg::*; (
    input  logic                          i_clk,
    input  logic [LANE_STG-1:0]           i_en,
    input  logic                          i_mode,
    input  logic                          i_active,
    input  logic signed [15:0]            i_ci,
    input  logic signed [15:0]            i_ki,
    input  logic [LANES-1:0][W_W-1:0]     i_w,
    input  logic [W_W-1:0]                i_wself,
    input  logic [LANES-1:0]              i_cmask,
    input  logic [LANES-1:0][15:0]        i_p,
    input  logic [LANES-1:0][DIFF_W-1:0]  i_diff,
    input  logic signed [15:0]            i_p_own,
    input  logic signed [DIFF_W-1:0]      i_diff_own,
    input  logic signed [15:0]            i_cur,
    output logic signed [15:0]            o_next,
    output logic signed [15:0]            o_term
);

    logic signed [50:0]       r_pr [LANES];
    logic [23:0]              r_rw;
    logic signed [18:0]       r_c1, r_c2, r_c3;
    logic signed [DIFF_W-1:0] r_diff1;
    logic signed [15:0]       r_cur1, r_cur2, r_cur3;
    logic signed [36:0]       r_l;
    logic signed [57:0]       r_pm;
    logic signed [34:0]       r_kc;
    logic signed [53:0]       r_t;
    logic signed [59:0]       r_acc;
    logic signed [15:0]       r_next, r_term;

    logic signed [50:0] n_pr [LANES];
    logic [23:0]        n_rw;
    logic signed [18:0] n_c;

    always_comb begin
        logic signed [18:0] csum;
        csum = '0;
        for (int j = 0; j < LANES; j++) begin
            n_pr[j] = signed'({1'b0, i_w[j]}) * signed'(i_diff[j]);
            if (i_cmask[j]) begin
                csum = csum + 19'(i_p_own) - 19'(signed'(i_p[j]));
            end
        end
        n_rw = 24'((32'(i_wself) * 32'(i_ci[14:0]) + 32'd128) >> 8);
        n_c  = (i_ki > 0) ? csum : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pr    <= n_pr;
            r_rw    <= n_rw;
            r_c1    <= n_c;
            r_diff1 <= i_diff_own;
            r_cur1  <= i_cur;
        end
    end

    logic signed [52:0] sum;
    logic signed [57:0] n_pm;
    logic signed [34:0] n_kc;

    always_comb begin
        sum = '0;
        for (int j = 0; j < LANES; j++) begin
            sum = sum + 53'(r_pr[j]);
        end
        n_pm = signed'({1'b0, r_rw}) * r_diff1;
        n_kc = i_ki * r_c1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_l    <= 37'(rnd(64'(sum), 16));
            r_pm   <= n_pm;
            r_kc   <= n_kc;
            r_c2   <= r_c1;
            r_cur2 <= r_cur1;
        end
    end

    logic signed [53:0] ct;
    logic signed [59:0] n_acc;

    always_comb begin
        ct    = i_ci * r_l;
        n_acc = 60'(r_cur2) <<< 24;
        if (i_ci > 0) begin
            n_acc = n_acc - 60'(r_pm);
        end
        n_acc = n_acc + (60'(r_kc) <<< 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_t    <= -ct;
            r_acc  <= n_acc;
            r_c3   <= r_c2;
            r_cur3 <= r_cur2;
        end
    end

    logic signed [15:0] n_next, n_term;

    always_comb begin
        n_next = r_cur3;
        n_term = '0;
        if (i_active) begin
            if (!i_mode) begin
                if (i_ci != 0) begin
                    n_term = sat16(rnd(64'(r_t), 16));
                    n_next = sat16(rnd((64'(r_cur3) <<< 16) + 64'(r_t), 16));
                end
            end else begin
                n_next = sat16(rnd(64'(r_acc), 24));
                n_term = sat16(64'(r_c3));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_next <= n_next;
            r_term <= n_term;
        end
    end

    assign o_next = r_next;
    assign o_term = r_term;

endmodule
